/* design/assert_macros.svh */
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset
`define AST_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, off during reset
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* design/swpm_pkg.sv */
package swpm_pkg;

    localparam int LETTER_W = 5;

    typedef enum logic {
        CMD_PATTERN = 1'b0,
        CMD_TEXT    = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd                cmd;
        logic [LETTER_W-1:0] letter;
        logic                start_req;
    } t_in_beat;

    typedef struct packed {
        logic window_full;
        logic window_match;
        logic found;
        logic pattern_overflow;
    } t_out_beat;

endpackage

/* design/sliding_window_permutation_match.sv */
// Streaming anagram search. Pattern beats build a letter histogram; text beats slide a
// window of the last k text letters (k = pattern length); each accepted in-range text
// beat yields one result beat. A beat is taken every clock cycle unless stalled: each
// letter has its own pair of counters updated in a single pass, and the letter leaving
// the window comes from a ring memory read from the next pointer and pattern length
// in the cycle before use, with a bypass when that read hits the entry being written.
// The input stalls only while the result register is full and the output is stalled.
// No clearing pass is needed after reset; start_req clears a query in the same cycle.
module sliding_window_permutation_match
    import swpm_pkg::*;
#(
    parameter int MAX_PATTERN = 256,
    parameter int ALPHABET    = 26
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);

    localparam int CW = $clog2(MAX_PATTERN + 1);
    localparam int PW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int AW = CW + 1;

    logic [CW-1:0]       r_pc [ALPHABET];
    logic [CW-1:0]       r_wc [ALPHABET];
    logic [CW-1:0]       n_pc [ALPHABET];
    logic [CW-1:0]       n_wc [ALPHABET];
    logic [LETTER_W-1:0] r_ring [MAX_PATTERN];
    logic [CW-1:0]       r_plen, n_plen;
    logic [CW-1:0]       r_fill, n_fill;
    logic [PW-1:0]       r_ptr, n_ptr;
    logic                r_found, n_found;
    logic                r_ovf, n_ovf;
    logic [LETTER_W-1:0] r_rd_data;
    logic                r_byp;
    logic [LETTER_W-1:0] r_byp_data;
    logic                r_out_valid, n_out_valid;
    t_out_beat           r_out_data, n_out_data;

    logic                in_acc, clr, is_text, letter_ok;
    logic                pat_upd, ovf_set, txt_hit, txt_empty, txt_upd, was_full;
    logic                full, eq_all;
    logic [CW-1:0]       e_plen, e_fill;
    logic [PW-1:0]       e_ptr;
    logic                e_found, e_ovf;
    logic [LETTER_W-1:0] outgoing;
    logic [CW-1:0]       inc_cnt;
    logic                inc, dec;
    logic [AW-1:0]       ra_sum;
    logic [PW-1:0]       rd_addr;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign clr         = in_acc && i_in_data.start_req;
    assign is_text     = (i_in_data.cmd == CMD_TEXT);
    assign letter_ok   = int'(i_in_data.letter) < ALPHABET;
    assign outgoing    = r_byp ? r_byp_data : r_rd_data;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        e_plen  = clr ? '0 : r_plen;
        e_fill  = clr ? '0 : r_fill;
        e_ptr   = clr ? '0 : r_ptr;
        e_found = clr ? 1'b0 : r_found;
        e_ovf   = clr ? 1'b0 : r_ovf;

        pat_upd   = in_acc && !is_text && letter_ok && (e_fill == '0)
                    && (e_plen != CW'(MAX_PATTERN));
        ovf_set   = in_acc && !is_text && letter_ok && (e_fill == '0)
                    && (e_plen == CW'(MAX_PATTERN));
        txt_hit   = in_acc && is_text && letter_ok;
        txt_empty = txt_hit && (e_plen == '0);
        txt_upd   = txt_hit && (e_plen != '0);
        was_full  = e_fill >= e_plen;

        eq_all = 1'b1;
        for (int i = 0; i < ALPHABET; i++) begin
            n_pc[i] = (clr ? '0 : r_pc[i])
                      + CW'(pat_upd && (int'(i_in_data.letter) == i));
            inc     = txt_upd && (int'(i_in_data.letter) == i);
            inc_cnt = (clr ? '0 : r_wc[i]) + CW'(inc);
            dec     = txt_upd && was_full && (int'(outgoing) == i) && (inc_cnt != '0);
            n_wc[i] = inc_cnt - CW'(dec);
            eq_all  = eq_all && (n_pc[i] == n_wc[i]);
        end

        n_plen = e_plen + CW'(pat_upd);
        n_fill = e_fill + CW'(txt_upd && !was_full);
        if (txt_upd) begin
            n_ptr = (e_ptr == PW'(MAX_PATTERN - 1)) ? '0 : e_ptr + PW'(1);
        end else begin
            n_ptr = e_ptr;
        end
        full    = n_fill >= e_plen;
        n_found = e_found || txt_empty || (txt_upd && full && eq_all);
        n_ovf   = e_ovf || ovf_set;

        ra_sum = AW'(n_ptr) + AW'(MAX_PATTERN) - AW'(n_plen);
        if (ra_sum >= AW'(MAX_PATTERN)) begin
            ra_sum = ra_sum - AW'(MAX_PATTERN);
        end
        rd_addr = PW'(ra_sum);

        n_out_valid = txt_hit || (r_out_valid && i_out_stall);
        n_out_data  = r_out_data;
        if (txt_hit) begin
            n_out_data.window_full      = txt_empty || full;
            n_out_data.window_match     = txt_empty || (full && eq_all);
            n_out_data.found            = n_found;
            n_out_data.pattern_overflow = n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen      <= '0;
            r_fill      <= '0;
            r_ptr       <= '0;
            r_found     <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < ALPHABET; i++) begin
                r_pc[i] <= '0;
                r_wc[i] <= '0;
            end
        end else begin
            r_out_valid <= n_out_valid;
            if (in_acc) begin
                r_plen  <= n_plen;
                r_fill  <= n_fill;
                r_ptr   <= n_ptr;
                r_found <= n_found;
                r_ovf   <= n_ovf;
                for (int i = 0; i < ALPHABET; i++) begin
                    r_pc[i] <= n_pc[i];
                    r_wc[i] <= n_wc[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (txt_upd) begin
            r_ring[e_ptr] <= i_in_data.letter;
        end
        r_rd_data  <= r_ring[rd_addr];
        r_byp      <= txt_upd && (e_ptr == rd_addr);
        r_byp_data <= i_in_data.letter;
    end

endmodule

/* design/swpm_checker.sv */
`include "assert_macros.svh"

module swpm_checker
    import swpm_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_beat  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_beat o_out_data
);

    logic in_seen;

    assign in_seen = i_in_valid && (i_in_data.letter == i_in_data.letter);

    `AST_IMPLY(a_match_full, i_clk, i_rst_n, o_out_valid && o_out_data.window_match, o_out_data.window_full)
    `AST_IMPLY(a_match_found, i_clk, i_rst_n, o_out_valid && o_out_data.window_match, o_out_data.found)
    `AST_IMPLY(a_stall_cause, i_clk, i_rst_n, o_in_stall || (in_seen && o_in_stall), o_out_valid && i_out_stall)
    `AST_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

endmodule

bind sliding_window_permutation_match swpm_checker u_swpm_checker (.*);

/* tb/sv/swpm_window_checker.sv */
module swpm_window_checker
    import swpm_pkg::*;
#(
    parameter int MAX_LEN   = 256,
    parameter int N_LETTERS = 26
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_beat  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_beat i_out_data,
    output int        o_errors,
    output int        o_pending,
    output int        o_results,
    output int        o_matches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_CAP = 40;

    int unsigned         pat_hist [N_LETTERS];
    int unsigned         win_hist [N_LETTERS];
    logic [LETTER_W-1:0] ring [MAX_LEN];
    int unsigned         pat_len;
    int unsigned         fill;
    int unsigned         head;
    int unsigned         agree;
    bit                  found_q;
    bit                  ovf_q;
    t_out_beat           results_due [$];

    function automatic void clear_query();
        foreach (pat_hist[i]) begin
            pat_hist[i] = 0;
            win_hist[i] = 0;
        end
        pat_len = 0;
        fill    = 0;
        head    = 0;
        agree   = N_LETTERS;
        found_q = 1'b0;
        ovf_q   = 1'b0;
    endfunction

    // keep the count of agreeing letters in step with one histogram change
    function automatic void shift_count(input bit on_pattern, input int unsigned c,
                                        input bit up);
        if (pat_hist[c] == win_hist[c])
            agree--;
        if (on_pattern)
            pat_hist[c] = up ? pat_hist[c] + 1 : pat_hist[c] - 1;
        else
            win_hist[c] = up ? win_hist[c] + 1 : win_hist[c] - 1;
        if (pat_hist[c] == win_hist[c])
            agree++;
    endfunction

    function automatic bit predict_window(input t_in_beat b, output t_out_beat r);
        int unsigned         c;
        int unsigned         k;
        int unsigned         tail;
        logic [LETTER_W-1:0] leaving;
        bit                  was_full;
        r = '0;
        c = int'(b.letter);
        if (b.start_req)
            clear_query();
        if (c >= N_LETTERS)
            return 1'b0;
        if (b.cmd == CMD_PATTERN) begin
            if (fill != 0)
                return 1'b0;
            if (pat_len >= MAX_LEN) begin
                ovf_q = 1'b1;
                return 1'b0;
            end
            shift_count(1'b1, c, 1'b1);
            pat_len++;
            return 1'b0;
        end
        k = pat_len;
        if (k == 0) begin
            found_q            = 1'b1;
            r.window_full      = 1'b1;
            r.window_match     = 1'b1;
            r.found            = 1'b1;
            r.pattern_overflow = ovf_q;
            return 1'b1;
        end
        tail     = (head + MAX_LEN - k) % MAX_LEN;
        leaving  = ring[tail];
        was_full = (fill >= k);
        shift_count(1'b0, c, 1'b1);
        if (was_full && int'(leaving) < N_LETTERS && win_hist[leaving] > 0)
            shift_count(1'b0, int'(leaving), 1'b0);
        ring[head] = b.letter;
        head       = (head + 1) % MAX_LEN;
        if (!was_full)
            fill++;
        r.window_full  = (fill >= k);
        r.window_match = r.window_full && (agree == N_LETTERS);
        if (r.window_match)
            found_q = 1'b1;
        r.found            = found_q;
        r.pattern_overflow = ovf_q;
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_out_beat predicted;
        t_out_beat want;
        if (!i_rst_n) begin
            clear_query();
            foreach (ring[i])
                ring[i] = '0;
            results_due.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                if (predict_window(i_in_data, predicted))
                    results_due.push_back(predicted);
            end
            if (i_out_valid && !i_out_stall) begin
                o_results++;
                if (results_due.size() == 0) begin
                    o_errors++;
                    if (o_errors <= REPORT_CAP)
                        $display("%0t: unexpected result %b, none outstanding",
                                 $time, i_out_data);
                end else begin
                    want = results_due.pop_front();
                    if (want.window_match)
                        o_matches++;
                    if (i_out_data.window_full !== want.window_full
                        || i_out_data.window_match !== want.window_match
                        || i_out_data.found !== want.found
                        || i_out_data.pattern_overflow !== want.pattern_overflow) begin
                        o_errors++;
                        if (o_errors <= REPORT_CAP)
                            $display("%0t: mismatch (full,match,found,overflow) %s %b got %b",
                                     $time, "expected", want, i_out_data);
                    end
                end
            end
        end
        o_pending = results_due.size();
    end

endmodule

/* tb/sv/tb_sliding_window_permutation_match.sv */
module tb_sliding_window_permutation_match;
    timeunit 1ns;
    timeprecision 1ps;

    import swpm_pkg::*;

    localparam int MAX_LEN    = 256;
    localparam int N_LETTERS  = 26;
    localparam int BEAT_GOAL  = 950;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN      = 20;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_beat  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_beat o_out_data;

    int        errors;
    int        pending;
    int        results;
    int        match_total;
    int        beats_sent;
    int        queries;
    int        idle_run;
    bit        calm;

    sliding_window_permutation_match #(
        .MAX_PATTERN(MAX_LEN),
        .ALPHABET   (N_LETTERS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    swpm_window_checker #(
        .MAX_LEN  (MAX_LEN),
        .N_LETTERS(N_LETTERS)
    ) u_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .i_out_data (o_out_data),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_results  (results),
        .o_matches  (match_total)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_in_beat make_beat(input t_cmd cmd, input int unsigned letter,
                                           input bit start);
        t_in_beat b;
        b.cmd       = cmd;
        b.letter    = letter[LETTER_W-1:0];
        b.start_req = start;
        return b;
    endfunction

    task automatic rest(input int unsigned n);
        repeat (n) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            i_in_data  <= make_beat(t_cmd'($urandom_range(1)), $urandom_range(31),
                                    $urandom_range(1));
        end
    endtask

    task automatic send_beat(input t_cmd cmd, input int unsigned letter, input bit start,
                             input bit counted);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= make_beat(cmd, letter, start);
        do @(posedge i_clk); while (o_in_stall);
        if (counted)
            beats_sent++;
        if (!calm)
            rest(pick_gap());
    endtask

    task automatic run_query(input int unsigned pat_n, input int unsigned span,
                             input bit plant);
        int unsigned pat [$];
        int unsigned txt [$];
        int unsigned kept;
        int unsigned base;
        int unsigned pick;
        int unsigned tmp;
        bit          fresh;
        bit          texted;
        fresh  = 1'b1;
        texted = 1'b0;
        for (int i = 0; i < pat_n; i++)
            pat.push_back($urandom_range(span - 1));
        kept = (pat_n > MAX_LEN) ? MAX_LEN : pat_n;
        if (plant) begin
            repeat ($urandom_range(8))
                txt.push_back($urandom_range(span - 1));
            base = txt.size();
            for (int i = 0; i < kept; i++)
                txt.push_back(pat[i]);
            for (int i = kept - 1; i > 0; i--) begin
                pick           = $urandom_range(i);
                tmp            = txt[base + i];
                txt[base + i]  = txt[base + pick];
                txt[base + pick] = tmp;
            end
            repeat ($urandom_range(6))
                txt.push_back($urandom_range(span - 1));
        end else begin
            repeat ($urandom_range(kept + 10))
                txt.push_back($urandom_range(span - 1));
        end
        foreach (pat[i]) begin
            send_beat(CMD_PATTERN, pat[i], fresh, 1'b1);
            fresh = 1'b0;
        end
        foreach (txt[i]) begin
            if (texted && $urandom_range(99) < 4)
                send_beat(CMD_PATTERN, $urandom_range(span - 1), 1'b0, 1'b0);
            if ($urandom_range(99) < 4)
                send_beat(t_cmd'($urandom_range(1)), $urandom_range(N_LETTERS, 31),
                          1'b0, 1'b0);
            send_beat(CMD_TEXT, txt[i], fresh || ($urandom_range(99) == 0), 1'b1);
            fresh  = 1'b0;
            texted = 1'b1;
        end
    endtask

    initial begin
        int unsigned n;
        i_out_stall = 1'b0;
        forever begin
            n = ($urandom_range(9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
            repeat (n) @(negedge i_clk) i_out_stall <= 1'b0;
            n = pick_gap();
            repeat (n) @(negedge i_clk) i_out_stall <= 1'b1;
        end
    end

    initial begin
        idle_run = 0;
        while (idle_run < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        int unsigned r;
        int unsigned len;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        calm       = 1'b0;
        beats_sent = 0;
        queries    = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // two-letter pattern, matching window, then ignored beats
        send_beat(CMD_PATTERN, 0, 1'b1, 1'b1);
        send_beat(CMD_PATTERN, 25, 1'b0, 1'b1);
        send_beat(CMD_TEXT, 25, 1'b0, 1'b1);
        send_beat(CMD_TEXT, 0, 1'b0, 1'b1);
        send_beat(CMD_TEXT, 31, 1'b0, 1'b0);
        send_beat(CMD_PATTERN, 3, 1'b0, 1'b0);
        send_beat(CMD_TEXT, 1, 1'b0, 1'b1);
        send_beat(CMD_TEXT, 25, 1'b0, 1'b1);
        // empty pattern
        send_beat(CMD_TEXT, 5, 1'b1, 1'b1);
        send_beat(CMD_TEXT, 16, 1'b0, 1'b1);
        // out-of-range pattern letters dropped
        send_beat(CMD_PATTERN, 30, 1'b1, 1'b0);
        send_beat(CMD_PATTERN, 26, 1'b0, 1'b0);
        send_beat(CMD_PATTERN, 2, 1'b0, 1'b1);
        send_beat(CMD_PATTERN, 8, 1'b0, 1'b1);
        send_beat(CMD_TEXT, 8, 1'b0, 1'b1);
        send_beat(CMD_TEXT, 4, 1'b0, 1'b1);
        send_beat(CMD_TEXT, 2, 1'b0, 1'b1);
        // text shorter than pattern
        send_beat(CMD_PATTERN, 1, 1'b1, 1'b1);
        send_beat(CMD_PATTERN, 2, 1'b0, 1'b1);
        send_beat(CMD_PATTERN, 3, 1'b0, 1'b1);
        send_beat(CMD_TEXT, 3, 1'b0, 1'b1);
        send_beat(CMD_TEXT, 2, 1'b0, 1'b1);
        queries = 4;

        while (beats_sent < BEAT_GOAL) begin
            calm = ($urandom_range(3) == 0);
            if (queries == 6) begin
                run_query(MAX_LEN + 3, N_LETTERS, 1'b1);
            end else begin
                r = $urandom_range(99);
                if (r < 6)
                    len = 0;
                else if (r < 88)
                    len = $urandom_range(1, 6);
                else
                    len = $urandom_range(7, 40);
                run_query(len, $urandom_range(1) ? $urandom_range(2, 4) : N_LETTERS,
                          $urandom_range(99) < 65);
            end
            queries++;
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);

        $display("covered %0d queries and %0d letter beats, one pattern past its limit",
                 queries, beats_sent);
        $display("checked %0d results, %0d of them matching windows", results, match_total);
        if (errors == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
